// File: hdl/ilut_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilut_pkg: shared constants for the interpolating lookup table
// Default sizes, register indexes, register reset values and the fixed
// widths of the configuration and address fields.
// ----------------------------------------------------------------------------
package ilut_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_TABLE_DEPTH  = 256;
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_VALUE_WIDTH  = 16;

  // fixed field widths
  localparam int FRAC_BITS   = 16;
  localparam int SCALE_W     = 24;
  localparam int ENTRIES_W   = 9;
  localparam int INDEX_W     = 8;
  localparam int CFG_INDEX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_LOWER_LIMIT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_SCALE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES_USED = 2'd2;

  // register reset values
  localparam logic [SCALE_W-1:0]   GRID_SCALE_RESET   = 24'd65536;
  localparam logic [ENTRIES_W-1:0] ENTRIES_USED_RESET = 9'd256;

endpackage

// File: hdl/ilut_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilut_ram: generic RAM, one write port, two read ports
// Read data is registered and only updates when the read enable is high,
// so it holds while the downstream pipeline is stalled.
// ----------------------------------------------------------------------------
module ilut_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hdl/interpolating_lookup_table.sv
`timescale 1ns / 1ps
// Path: a sample word passes stages 1 to 6 and the output register before it
//   shows on out_valid, and waits there while out_ready is low.
// Throughput: one word per cycle; the whole six-stage pipeline advances together
//   and holds while a result waits at the output register.
// Reset: synchronous, active low; clears the pipeline valids and resets the config
//   registers. The table RAM is not cleared; entries must be written before use.
// ----------------------------------------------------------------------------
// interpolating_lookup_table: streaming uniform-grid table with linear
// interpolation. Table writes and sample lookups share the input channel.
// ----------------------------------------------------------------------------
module interpolating_lookup_table #(
  parameter int TABLE_DEPTH  = ilut_pkg::DEF_TABLE_DEPTH,
  parameter int SAMPLE_WIDTH = ilut_pkg::DEF_SAMPLE_WIDTH,
  parameter int VALUE_WIDTH  = ilut_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ilut_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [((SAMPLE_WIDTH > ilut_pkg::SCALE_W) ? SAMPLE_WIDTH
                 : ilut_pkg::SCALE_W)-1:0]    cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  input  logic                                in_mask_enable,
  input  logic                                in_last_sample,
  input  logic [ilut_pkg::INDEX_W-1:0]        in_entry_index,
  input  logic signed [VALUE_WIDTH-1:0]       in_entry_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [VALUE_WIDTH-1:0]       out_value,
  output logic                                out_in_range,
  output logic                                out_last
);

  import ilut_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);           // table address
  localparam int NW  = $clog2(TABLE_DEPTH);           // holds DEPTH-1
  localparam int DW  = SAMPLE_WIDTH + 1;              // sample - lower_limit
  localparam int PW  = DW + SCALE_W + 1;              // position, Q.16
  localparam int IXW = PW - 1 - FRAC_BITS;            // whole part of position
  localparam int CW  = (IXW > NW) ? IXW : NW;         // compare width
  localparam int EW  = VALUE_WIDTH + 1;               // entry difference
  localparam int MW  = EW + FRAC_BITS + 1;            // difference * fraction

  // reciprocal of the depth for wrapping the write index
  localparam int WRAP_SH = INDEX_W + AW;
  localparam int WRAP_M  = ((1 << WRAP_SH) + TABLE_DEPTH - 1) / TABLE_DEPTH;
  localparam int WRAP_PW = WRAP_SH + INDEX_W + 2;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_WIDTH-1:0] lower_limit_r;
  logic [SCALE_W-1:0]             grid_scale_r;
  logic [ENTRIES_W-1:0]           entries_used_r;
  logic [NW-1:0]                  last_ix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_limit_r  <= '0;
      grid_scale_r   <= GRID_SCALE_RESET;
      entries_used_r <= ENTRIES_USED_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOWER_LIMIT:  lower_limit_r  <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_GRID_SCALE:   grid_scale_r   <= cfg_data[SCALE_W-1:0];
        REG_ENTRIES_USED: entries_used_r <= cfg_data[ENTRIES_W-1:0];
        default: ;
      endcase
    end
  end

  // index of the last entry in use, entries_used saturated to 2..DEPTH
  always_comb begin
    if (entries_used_r < ENTRIES_W'(2)) begin
      last_ix = NW'(1);
    end else if (32'(entries_used_r) > TABLE_DEPTH) begin
      last_ix = NW'(TABLE_DEPTH - 1);
    end else begin
      last_ix = NW'(entries_used_r - ENTRIES_W'(1));
    end
  end

  // --------------------------------------------------------------------------
  // global pipeline advance: every stage moves unless a result is stuck
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // --------------------------------------------------------------------------
  // stage 1: input capture
  // --------------------------------------------------------------------------
  logic                          v1_r, k1_r, m1_r, l1_r;
  logic signed [SAMPLE_WIDTH-1:0] smp1_r;
  logic [INDEX_W-1:0]            idx1_r;
  logic [VALUE_WIDTH-1:0]        wval1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1_r    <= in_kind;
      m1_r    <= in_mask_enable;
      l1_r    <= in_last_sample;
      smp1_r  <= in_sample;
      idx1_r  <= in_entry_index;
      wval1_r <= in_entry_value;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: offset from lower limit, write address wrapped to the depth
  // --------------------------------------------------------------------------
  logic                  v2_r, k2_r, m2_r, l2_r;
  logic signed [DW-1:0]  diff2_r;
  logic [AW-1:0]         waddr2_r;
  logic [VALUE_WIDTH-1:0] wval2_r;
  logic signed [DW-1:0]  diff_nxt;
  logic [INDEX_W-1:0]    wrap;
  logic [WRAP_PW-1:0]    wrap_prod;
  logic [WRAP_PW-WRAP_SH-1:0] wrap_q;

  assign diff_nxt = {smp1_r[SAMPLE_WIDTH-1], smp1_r}
                  - {lower_limit_r[SAMPLE_WIDTH-1], lower_limit_r};

  // remainder of the index by the depth: quotient by reciprocal multiply
  assign wrap_prod = WRAP_PW'(idx1_r) * WRAP_PW'(WRAP_M);
  assign wrap_q    = wrap_prod[WRAP_PW-1:WRAP_SH];
  assign wrap      = INDEX_W'(32'(idx1_r) - 32'(wrap_q) * TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k2_r     <= k1_r;
      m2_r     <= m1_r;
      l2_r     <= l1_r;
      diff2_r  <= diff_nxt;
      waddr2_r <= AW'(wrap);
      wval2_r  <= wval1_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: table position = offset * grid_scale
  // --------------------------------------------------------------------------
  logic                   v3_r, k3_r, m3_r, l3_r;
  logic signed [PW-1:0]   pos3_r;
  logic signed [PW-1:0]   pos_nxt;
  logic [AW-1:0]          waddr3_r;
  logic [VALUE_WIDTH-1:0] wval3_r;

  assign pos_nxt = diff2_r * $signed({1'b0, grid_scale_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k3_r     <= k2_r;
      m3_r     <= m2_r;
      l3_r     <= l2_r;
      pos3_r   <= pos_nxt;
      waddr3_r <= waddr2_r;
      wval3_r  <= wval2_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3 -> 4: range check, table access (writes and reads in order)
  // --------------------------------------------------------------------------
  logic [IXW-1:0]       ix;
  logic [FRAC_BITS-1:0] frac;
  logic                 pos_neg;
  logic                 inr;
  logic [AW-1:0]        raddr_a;
  logic [AW-1:0]        raddr_b;
  logic [VALUE_WIDTH-1:0] e0_rd;
  logic [VALUE_WIDTH-1:0] e1_rd;

  assign pos_neg = pos3_r[PW-1];
  assign ix      = pos3_r[PW-2:FRAC_BITS];
  assign frac    = pos3_r[FRAC_BITS-1:0];
  assign raddr_a = ix[AW-1:0];
  assign raddr_b = ix[AW-1:0] + AW'(1);

  // inside the table, or exactly on the last entry
  assign inr = !pos_neg
            && ((CW'(ix) < CW'(last_ix))
             || ((CW'(ix) == CW'(last_ix)) && (frac == '0)));

  ilut_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (en && v3_r && k3_r),
    .waddr   (waddr3_r),
    .wdata   (wval3_r),
    .re      (en && v3_r && !k3_r),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (e0_rd),
    .rdata_b (e1_rd)
  );

  logic                 v4_r, m4_r, l4_r, inr4_r, fz4_r;
  logic [FRAC_BITS-1:0] frac4_r;

  // write words end here; only lookups travel on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r && !k3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m4_r    <= m3_r;
      l4_r    <= l3_r;
      inr4_r  <= inr;
      fz4_r   <= (frac == '0);
      frac4_r <= frac;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: difference of neighbors (next entry ignored on whole positions)
  // --------------------------------------------------------------------------
  logic                    v5_r, m5_r, l5_r, inr5_r;
  logic [FRAC_BITS-1:0]    frac5_r;
  logic signed [VALUE_WIDTH-1:0] e0_5_r;
  logic signed [EW-1:0]    dval5_r;
  logic signed [VALUE_WIDTH-1:0] e1_sel;

  assign e1_sel = fz4_r ? e0_rd : e1_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m5_r    <= m4_r;
      l5_r    <= l4_r;
      inr5_r  <= inr4_r;
      frac5_r <= frac4_r;
      e0_5_r  <= e0_rd;
      dval5_r <= {e1_sel[VALUE_WIDTH-1], e1_sel} - {e0_rd[VALUE_WIDTH-1], e0_rd};
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: difference * fraction
  // --------------------------------------------------------------------------
  logic                          v6_r, m6_r, l6_r, inr6_r;
  logic signed [VALUE_WIDTH-1:0] e0_6_r;
  logic signed [MW-1:0]          prod6_r;
  logic signed [MW-1:0]          prod_nxt;

  assign prod_nxt = dval5_r * $signed({1'b0, frac5_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m6_r    <= m5_r;
      l6_r    <= l5_r;
      inr6_r  <= inr5_r;
      e0_6_r  <= e0_5_r;
      prod6_r <= prod_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // output register: entry + floor(product / 2^16), masking and range
  // --------------------------------------------------------------------------
  logic signed [EW:0]            step;
  logic signed [EW:0]            interp;
  logic signed [VALUE_WIDTH-1:0] value_nxt;
  logic                          in_range_nxt;
  logic signed [VALUE_WIDTH-1:0] out_value_r;
  logic                          out_in_range_r;
  logic                          out_last_r;

  assign step   = prod6_r[MW-1:FRAC_BITS];
  assign interp = {{2{e0_6_r[VALUE_WIDTH-1]}}, e0_6_r} + step;

  always_comb begin
    if (m6_r && inr6_r) begin
      value_nxt = interp[VALUE_WIDTH-1:0];
    end else begin
      value_nxt = '0;
    end
    // samples with the mask enable low always report in range
    in_range_nxt = !m6_r || inr6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r    <= value_nxt;
      out_in_range_r <= in_range_nxt;
      out_last_r     <= l6_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_in_range = out_in_range_r;
  assign out_last     = out_last_r;

endmodule

// File: hdl/ilut_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilut_checker: port-level checks for the interpolating lookup table
// Watches the result channel and the input backpressure; bound to the top.
// ----------------------------------------------------------------------------
module ilut_checker #(
  parameter int VALUE_WIDTH = ilut_pkg::DEF_VALUE_WIDTH
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_value,
  input logic                   out_in_range
);

  // reset empties the result register
  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds its word
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
                                && $stable(out_in_range))
    else $error("result word changed while stalled");

  // a result outside the table carries zero
  a_out_of_range_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> out_value == '0)
    else $error("out of range result is not zero");

  // a stuck result stops the input side
  a_backpressure : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

endmodule

bind interpolating_lookup_table ilut_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_ilut_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_value    (out_value),
  .out_in_range (out_in_range)
);
